### src/midi_track_event_parser_defines.svh
// Assertion macros for the checker file of the MIDI track event parser.
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MTEP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mtep: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define MTEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mtep: next-cycle check failed");

`endif

### src/mtep_pkg.sv
// Types, codes and helpers shared by the MIDI track event parser modules.
`default_nettype none
package mtep_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int VLQ_GROUPS_DEF = 4;
    localparam int ACC_BITS       = 28;

    // status bytes and masks
    localparam logic [7:0] B_DATA_MASK = 8'h7F;
    localparam logic [7:0] B_STATUS    = 8'h80;
    localparam logic [7:0] B_META      = 8'hFF;
    localparam logic [7:0] B_EOX       = 8'hF7;
    localparam logic [7:0] B_SYSEX     = 8'hF0;
    localparam logic [7:0] B_RT_LO     = 8'hF8;
    localparam logic [7:0] B_RT_HI     = 8'hFE;
    localparam logic [7:0] B_EOT_TYPE  = 8'h2F;
    localparam logic [7:0] B_SONG_POS  = 8'hF2;
    localparam logic [7:0] B_MTC_QF    = 8'hF1;
    localparam logic [7:0] B_SONG_SEL  = 8'hF3;
    localparam logic [7:0] B_UNDEF_F4  = 8'hF4;
    localparam logic [7:0] B_UNDEF_F5  = 8'hF5;
    localparam logic [7:0] B_UNDEF_FD  = 8'hFD;
    localparam logic [3:0] HI_PROG     = 4'hC;
    localparam logic [3:0] HI_CHPRESS  = 4'hD;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_STATUS = 3'd1;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd2;
    localparam logic [2:0] ERR_TRUNC     = 3'd3;
    localparam logic [2:0] ERR_OVERLONG  = 3'd4;
    localparam logic [2:0] ERR_SYSEX     = 3'd5;

    typedef enum logic [7:0] {
        PH_DELTA  = 8'b0000_0001,
        PH_STATUS = 8'b0000_0010,
        PH_DATA   = 8'b0000_0100,
        PH_MTYPE  = 8'b0000_1000,
        PH_MLEN   = 8'b0001_0000,
        PH_MDATA  = 8'b0010_0000,
        PH_SYSEX  = 8'b0100_0000,
        PH_HALT   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0]  msg;
        logic [15:0] idx;
        logic [31:0] tm;
        logic        done;
        logic        rt;
        logic        ended;
        logic [2:0]  err;
        logic        last;
    } t_result;

    // results caused by one request, count 0..2
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_core_out;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // shift in one 7-bit group, saturating at 28 bits
    function automatic logic [ACC_BITS-1:0] vlq_shift(input logic [ACC_BITS-1:0] acc,
                                                      input logic [7:0] b);
        logic [7:0] low;
        low = b & B_DATA_MASK;
        if (|acc[ACC_BITS-1:ACC_BITS-7]) begin
            return '1;
        end
        return {acc[ACC_BITS-8:0], low[6:0]};
    endfunction

    function automatic t_result mk_res(input logic [7:0] msg, input logic [15:0] idx,
                                       input logic done, input logic rt,
                                       input logic ended, input logic [2:0] err);
        t_result r;
        r.msg   = msg;
        r.idx   = idx;
        r.tm    = '0;
        r.done  = done;
        r.rt    = rt;
        r.ended = ended;
        r.err   = err;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

### src/mtep_core.sv
// Per-byte parsing rule and parser state of the MIDI track event parser.
`default_nettype none
module mtep_core #(
    parameter int TIME_BITS      = mtep_pkg::TIME_BITS_DEF,
    parameter int VLQ_MAX_GROUPS = mtep_pkg::VLQ_GROUPS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_take,
    input  wire [7:0]           i_data,
    input  wire                 i_first,
    input  wire                 i_last,
    output mtep_pkg::t_core_out o_out
);
    import mtep_pkg::*;

    localparam int GC_W = $clog2(VLQ_MAX_GROUPS + 1);

    t_phase                r_phase, n_phase;
    logic [7:0]            r_rs, n_rs;
    logic [TIME_BITS-1:0]  r_abs, n_abs;
    logic [ACC_BITS-1:0]   r_acc, n_acc;
    logic [GC_W-1:0]       r_gc, n_gc;
    logic [ACC_BITS-1:0]   r_rem, n_rem;
    logic [15:0]           r_idx, n_idx;
    logic                  r_done, n_done;

    t_phase                c_phase;
    logic [7:0]            c_rs;
    logic [TIME_BITS-1:0]  c_abs;
    logic [ACC_BITS-1:0]   c_acc, c_rem;
    logic [GC_W-1:0]       c_gc;
    logic [15:0]           c_idx;
    logic                  c_done;

    logic [ACC_BITS-1:0]   acc_v, rem_dec;
    logic [GC_W-1:0]       gc1;
    logic [TIME_BITS:0]    sum;
    logic [63:0]           abs_wide;
    logic [31:0]           tm_out;
    logic                  rt, prog;
    logic [3:0]            hi;
    logic [1:0]            cnt;
    t_result               res0, res1;

    always_comb begin
        // start-of-track clears everything before the byte is used
        c_phase = i_first ? PH_DELTA : r_phase;
        c_rs    = i_first ? '0 : r_rs;
        c_abs   = i_first ? '0 : r_abs;
        c_acc   = i_first ? '0 : r_acc;
        c_gc    = i_first ? '0 : r_gc;
        c_rem   = i_first ? '0 : r_rem;
        c_idx   = i_first ? '0 : r_idx;
        c_done  = i_first ? 1'b0 : r_done;

        n_phase = c_phase;
        n_rs    = c_rs;
        n_abs   = c_abs;
        n_acc   = c_acc;
        n_gc    = c_gc;
        n_rem   = c_rem;
        n_idx   = c_idx;
        n_done  = c_done;

        rt      = (i_data >= B_RT_LO) && (i_data <= B_RT_HI);
        acc_v   = vlq_shift(c_acc, i_data);
        gc1     = c_gc + GC_W'(1);
        rem_dec = c_rem - ACC_BITS'(1);
        sum     = {1'b0, c_abs} + (TIME_BITS + 1)'(acc_v);
        hi      = c_rs[7:4];
        prog    = 1'b0;
        cnt     = 2'd0;
        res0    = mk_res(i_data, c_idx, 1'b0, 1'b0, 1'b0, ERR_NONE);
        res1    = res0;

        case (c_phase)
            PH_DELTA: begin
                if (i_data[7]) begin
                    n_acc = acc_v;
                    n_gc  = gc1;
                    if (gc1 >= GC_W'(VLQ_MAX_GROUPS)) begin
                        res0    = mk_res(i_data, c_idx, 1'b1, 1'b0, 1'b0, ERR_OVERLONG);
                        cnt     = 2'd1;
                        n_phase = PH_HALT;
                    end
                end else begin
                    n_abs   = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
                    n_acc   = '0;
                    n_gc    = '0;
                    n_idx   = '0;
                    n_phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (i_data < B_STATUS) begin
                    if (c_rs == '0) begin
                        res0    = mk_res(i_data, c_idx, 1'b1, 1'b0, 1'b0, ERR_NO_STATUS);
                        cnt     = 2'd1;
                        n_phase = PH_HALT;
                    end else begin
                        // running status: status byte goes out first
                        prog    = (hi == HI_PROG) || (hi == HI_CHPRESS);
                        res0    = mk_res(c_rs, c_idx, 1'b0, 1'b0, 1'b0, ERR_NONE);
                        res1    = mk_res(i_data, sat_inc16(c_idx), prog, 1'b0, 1'b0,
                                         ERR_NONE);
                        cnt     = 2'd2;
                        n_idx   = sat_inc16(sat_inc16(c_idx));
                        n_rem   = prog ? '0 : ACC_BITS'(1);
                        n_phase = prog ? PH_DELTA : PH_DATA;
                    end
                end else if (i_data < B_SYSEX) begin
                    prog    = (i_data[7:4] == HI_PROG) || (i_data[7:4] == HI_CHPRESS);
                    n_rs    = i_data;
                    n_rem   = prog ? ACC_BITS'(1) : ACC_BITS'(2);
                    cnt     = 2'd1;
                    n_idx   = sat_inc16(c_idx);
                    n_phase = PH_DATA;
                end else if ((i_data == B_UNDEF_F4) || (i_data == B_UNDEF_F5)
                             || (i_data == B_UNDEF_FD)) begin
                    res0    = mk_res(i_data, c_idx, 1'b1, 1'b0, 1'b0, ERR_UNKNOWN);
                    cnt     = 2'd1;
                    n_phase = PH_HALT;
                end else if (i_data == B_SYSEX) begin
                    n_rs    = '0;
                    cnt     = 2'd1;
                    n_idx   = sat_inc16(c_idx);
                    n_phase = PH_SYSEX;
                end else if (i_data == B_META) begin
                    n_rs    = '0;
                    cnt     = 2'd1;
                    n_idx   = sat_inc16(c_idx);
                    n_phase = PH_MTYPE;
                end else if ((i_data == B_MTC_QF) || (i_data == B_SONG_POS)
                             || (i_data == B_SONG_SEL)) begin
                    n_rs    = '0;
                    n_rem   = (i_data == B_SONG_POS) ? ACC_BITS'(2) : ACC_BITS'(1);
                    cnt     = 2'd1;
                    n_idx   = sat_inc16(c_idx);
                    n_phase = PH_DATA;
                end else begin
                    // one-byte event; realtime leaves running status alone
                    if (i_data < B_RT_LO) begin
                        n_rs = '0;
                    end
                    res0.done = 1'b1;
                    cnt       = 2'd1;
                    n_idx     = sat_inc16(c_idx);
                    n_phase   = PH_DELTA;
                end
            end
            PH_DATA: begin
                cnt = 2'd1;
                if (rt) begin
                    res0 = mk_res(i_data, 16'd0, 1'b1, 1'b1, 1'b0, ERR_NONE);
                end else begin
                    n_rem     = rem_dec;
                    res0.done = (rem_dec == '0);
                    n_idx     = sat_inc16(c_idx);
                    if (rem_dec == '0) begin
                        n_phase = PH_DELTA;
                    end
                end
            end
            PH_MTYPE: begin
                n_done  = (i_data == B_EOT_TYPE);
                n_acc   = '0;
                n_gc    = '0;
                cnt     = 2'd1;
                n_idx   = sat_inc16(c_idx);
                n_phase = PH_MLEN;
            end
            PH_MLEN: begin
                cnt = 2'd1;
                if (i_data[7]) begin
                    n_acc = acc_v;
                    n_gc  = gc1;
                    if (gc1 >= GC_W'(VLQ_MAX_GROUPS)) begin
                        res0    = mk_res(i_data, c_idx, 1'b1, 1'b0, 1'b0, ERR_OVERLONG);
                        n_phase = PH_HALT;
                    end else begin
                        n_idx = sat_inc16(c_idx);
                    end
                end else begin
                    n_rem = acc_v;
                    n_acc = '0;
                    n_gc  = '0;
                    n_idx = sat_inc16(c_idx);
                    if (acc_v == '0) begin
                        res0.done  = 1'b1;
                        res0.ended = c_done;
                        n_phase    = c_done ? PH_HALT : PH_DELTA;
                    end else begin
                        n_phase = PH_MDATA;
                    end
                end
            end
            PH_MDATA: begin
                cnt   = 2'd1;
                n_rem = rem_dec;
                n_idx = sat_inc16(c_idx);
                if (rem_dec == '0) begin
                    res0.done  = 1'b1;
                    res0.ended = c_done;
                    n_phase    = c_done ? PH_HALT : PH_DELTA;
                end
            end
            PH_SYSEX: begin
                cnt = 2'd1;
                if (rt) begin
                    res0 = mk_res(i_data, 16'd0, 1'b1, 1'b1, 1'b0, ERR_NONE);
                end else if (i_data == B_EOX) begin
                    res0.done = 1'b1;
                    n_idx     = sat_inc16(c_idx);
                    n_phase   = PH_DELTA;
                end else if (i_data >= B_STATUS) begin
                    res0    = mk_res(i_data, c_idx, 1'b1, 1'b0, 1'b0, ERR_SYSEX);
                    n_phase = PH_HALT;
                end else begin
                    n_idx = sat_inc16(c_idx);
                end
            end
            PH_HALT: begin
                cnt = 2'd0;
            end
            default: begin
                cnt = 2'd0;
            end
        endcase

        // truncated event or delta on the final byte of the chunk
        if (i_last && (n_phase != PH_HALT) && ((n_phase != PH_DELTA) || (n_gc != '0))) begin
            if (cnt == 2'd0) begin
                res0 = mk_res(i_data, n_idx, 1'b1, 1'b0, 1'b0, ERR_TRUNC);
                cnt  = 2'd1;
            end else if (cnt == 2'd1) begin
                res0.done = 1'b1;
                res0.err  = ERR_TRUNC;
            end else begin
                res1.done = 1'b1;
                res1.err  = ERR_TRUNC;
            end
            n_phase = PH_HALT;
        end

        abs_wide = 64'(n_abs);
        tm_out   = (|abs_wide[63:32]) ? 32'hFFFF_FFFF : abs_wide[31:0];
        res0.tm  = tm_out;
        res1.tm  = tm_out;
        res0.last = (cnt == 2'd1);
        res1.last = 1'b1;

        o_out.count = cnt;
        o_out.res0  = res0;
        o_out.res1  = res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DELTA;
            r_rs    <= '0;
            r_abs   <= '0;
            r_acc   <= '0;
            r_gc    <= '0;
            r_rem   <= '0;
            r_idx   <= '0;
            r_done  <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_rs    <= n_rs;
            r_abs   <= n_abs;
            r_acc   <= n_acc;
            r_gc    <= n_gc;
            r_rem   <= n_rem;
            r_idx   <= n_idx;
            r_done  <= n_done;
        end
    end

endmodule
`default_nettype wire

### src/mtep_outbuf.sv
// Two-entry result register that decouples the parser from the output stream.
`default_nettype none
module mtep_outbuf (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  mtep_pkg::t_core_out i_res,
    input  wire                 i_ready,
    output logic                o_valid,
    output mtep_pkg::t_result   o_head,
    output logic                o_can_take
);
    import mtep_pkg::*;

    t_result    r_slot0, n_slot0;
    t_result    r_slot1, n_slot1;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_slot0;
    assign pop     = o_valid && i_ready;
    // a new request is taken only while the buffer is empty or drains this cycle
    assign o_can_take = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);

    always_comb begin
        n_slot0 = pop ? r_slot1 : r_slot0;
        n_slot1 = r_slot1;
        n_cnt   = r_cnt - {1'b0, pop};
        if (i_push) begin
            n_slot0 = i_res.res0;
            n_slot1 = i_res.res1;
            n_cnt   = i_res.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule
`default_nettype wire

### src/midi_track_event_parser.sv
// The first result of a request is registered in the output buffer and appears in the cycle after it is taken.
// Throughput: one byte per cycle while each byte yields at most one result and the
// sink is ready; a running-status byte yields two results and holds the next
// request back until its first result has left, as the output buffer has a single result port.
// Reset: synchronous, active low; clears parser state and empties the output buffer.
`default_nettype none
module midi_track_event_parser #(
    parameter int TIME_BITS      = mtep_pkg::TIME_BITS_DEF,
    parameter int VLQ_MAX_GROUPS = mtep_pkg::VLQ_GROUPS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tlast,   // last_of_track
    input  wire         s_axis_tuser,   // [0] first_of_track
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [7:0] msg_byte, [23:8] byte_index,
                                        // [55:24] event_time, [56] event_done,
                                        // [57] track_ended, [60:58] error_code
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser    // [0] realtime_event
);
    import mtep_pkg::*;

    logic      take;
    t_core_out core_out;
    t_result   head;

    assign take = s_axis_tvalid && s_axis_tready;

    mtep_core #(
        .TIME_BITS      (TIME_BITS),
        .VLQ_MAX_GROUPS (VLQ_MAX_GROUPS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (s_axis_tdata),
        .i_first (s_axis_tuser),
        .i_last  (s_axis_tlast),
        .o_out   (core_out)
    );

    mtep_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (take),
        .i_res      (core_out),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_head     (head),
        .o_can_take (s_axis_tready)
    );

    assign m_axis_tdata = {3'b000, head.err, head.ended, head.done, head.tm,
                           head.idx, head.msg};
    assign m_axis_tlast = head.last;
    assign m_axis_tuser = head.rt;

endmodule
`default_nettype wire

### src/mtep_checker.sv
// Port-level checker for the MIDI track event parser, bound to the top level.
`default_nettype none
`include "midi_track_event_parser_defines.svh"
module mtep_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [63:0] m_axis_tdata,
    input wire        m_axis_tlast,
    input wire        m_axis_tuser
);
    import mtep_pkg::*;

    logic res_stall;
    logic res_err;
    logic res_close;
    logic rt_shape;

    assign res_stall = m_axis_tvalid && !m_axis_tready;
    assign res_err   = m_axis_tvalid && (m_axis_tdata[60:58] != ERR_NONE);
    assign res_close = m_axis_tdata[56] && m_axis_tlast;
    // interleaved realtime: index zero, byte in F8..FE, complete
    assign rt_shape  = (m_axis_tdata[23:8] == 16'd0) && (m_axis_tdata[7:0] >= B_RT_LO)
                       && (m_axis_tdata[7:0] <= B_RT_HI) && m_axis_tdata[56];

    // stalled result stays offered
    `MTEP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, res_stall, m_axis_tvalid)

    // no new request while a stalled result still waits
    `MTEP_ASSERT_NOW(a_no_take, i_clk, i_rst_n, res_stall, !s_axis_tready)

    // an error result closes both the event and the byte's run
    `MTEP_ASSERT_NOW(a_err_done, i_clk, i_rst_n, res_err, res_close)

    `MTEP_ASSERT_NOW(a_rt, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, rt_shape)

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
